@@ rtl/core/isq_pkg.sv @@
`default_nettype none

package isq_pkg;

  // default sizing of the store
  localparam int ISQ_DEPTH  = 64;
  localparam int ISQ_DATA_W = 32;

  // fixed field widths of the channels
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int CNT_O_W = 7;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_REVERSE = 3'd4,
    OP_ORDERED = 3'd5,
    OP_READ    = 3'd6
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_REV_RDA,
    ST_REV_RDB,
    ST_REV_WRA,
    ST_REV_WRB,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  // one result word as handed from the engine to the output stage
  typedef struct packed {
    logic                      ok;
    logic                      full_flag;
    logic [CNT_O_W-1:0]        found_position;
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_O_W-1:0]        element_count;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/isq_ram.sv @@
`default_nettype none

module isq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/isq_engine.sv @@
`default_nettype none

module isq_engine import isq_pkg::*; #(
  parameter int DEPTH      = ISQ_DEPTH,
  parameter int DATA_WIDTH = ISQ_DATA_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [OP_W-1:0]           in_op,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [POS_W-1:0]          in_position,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output res_t                           res,
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output logic [DATA_WIDTH-1:0]          ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  input  wire logic [DATA_WIDTH-1:0]     ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         tgt_r, tgt_nxt;
  logic [CW-1:0]         hi_r, hi_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ok_r, ok_nxt;
  logic                  full_r, full_nxt;
  logic [CW-1:0]         found_r, found_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;

  logic                  accept;
  op_t                   in_opc;
  logic [63:0]           in_ext;
  logic [DATA_WIDTH-1:0] in_key;
  logic [PW-1:0]         pos_w, cnt_w;
  logic                  ins_ok, sel_ok, is_full, few;
  logic [CW-1:0]         pos_m1, ptr_m1, ptr_p1;
  logic                  at_tgt, del_end, srch_end, rev_go;
  logic                  eq, le, hit;
  logic signed [63:0]    rd_ext;

  // input decode
  assign accept   = in_valid && in_ready;
  assign in_opc   = op_t'(in_op);
  assign in_ext   = 64'($signed(in_value));
  assign in_key   = in_ext[DATA_WIDTH-1:0];
  assign pos_w    = PW'(in_position);
  assign cnt_w    = PW'(count_r);
  assign ins_ok   = (in_position != '0) && (pos_w <= cnt_w + PW'(1));
  assign sel_ok   = (in_position != '0) && (pos_w <= cnt_w);
  assign pos_m1   = CW'(pos_w - PW'(1));
  assign is_full  = (count_r == CW'(DEPTH));
  assign few      = (count_r < CW'(2));

  // loop bookkeeping
  assign ptr_m1   = ptr_r - 1'b1;
  assign ptr_p1   = ptr_r + 1'b1;
  assign at_tgt   = (ptr_r == tgt_r);
  assign del_end  = (ptr_p1 == count_r);
  assign srch_end = (ptr_r == count_r);
  assign rev_go   = (ptr_r < hi_r);

  // shared compare unit: equality for search, signed less-or-equal for ordered insert
  assign eq  = (ram_rdata == key_r);
  assign le  = ($signed(key_r) <= $signed(ram_rdata));
  assign hit = (op_r == OP_SEARCH) ? eq : le;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opc)
            OP_APPEND:  state_nxt = is_full ? ST_DONE : ST_SHIFT_RD;
            OP_INSERT:  state_nxt = (ins_ok && !is_full) ? ST_SHIFT_RD : ST_DONE;
            OP_DELETE:  state_nxt = sel_ok ? ST_DEL_RD : ST_DONE;
            OP_SEARCH:  state_nxt = ST_SRCH_RD;
            OP_ORDERED: state_nxt = is_full ? ST_DONE : ST_SRCH_RD;
            OP_REVERSE: state_nxt = few ? ST_DONE : ST_REV_RDA;
            OP_READ:    state_nxt = sel_ok ? ST_READ_RD : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SHIFT_RD:  state_nxt = at_tgt ? ST_DONE : ST_SHIFT_WR;
      ST_SHIFT_WR:  state_nxt = ST_SHIFT_RD;
      ST_DEL_RD:    state_nxt = del_end ? ST_DONE : ST_DEL_WR;
      ST_DEL_WR:    state_nxt = ST_DEL_RD;
      ST_SRCH_RD: begin
        if (srch_end) begin
          state_nxt = (op_r == OP_ORDERED) ? ST_SHIFT_RD : ST_DONE;
        end else begin
          state_nxt = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (hit) begin
          state_nxt = (op_r == OP_ORDERED) ? ST_SHIFT_RD : ST_DONE;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_REV_RDA:   state_nxt = rev_go ? ST_REV_RDB : ST_DONE;
      ST_REV_RDB:   state_nxt = ST_REV_WRA;
      ST_REV_WRA:   state_nxt = ST_REV_WRB;
      ST_REV_WRB:   state_nxt = ST_REV_RDA;
      ST_READ_RD:   state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_DONE:      state_nxt = res_ready ? ST_IDLE : ST_DONE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory port controls
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    ram_we    = 1'b0;
    ram_waddr = AW'(ptr_r);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = AW'(ptr_r);
    case (state_r)
      ST_SHIFT_RD: begin
        if (at_tgt) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(tgt_r);
          ram_wdata = key_r;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_m1);
        end
      end
      ST_SHIFT_WR: ram_we = 1'b1;
      ST_DEL_RD: begin
        ram_re    = !del_end;
        ram_raddr = AW'(ptr_p1);
      end
      ST_DEL_WR:  ram_we = 1'b1;
      ST_SRCH_RD: ram_re = !srch_end;
      ST_REV_RDA: ram_re = rev_go;
      ST_REV_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(hi_r);
      end
      ST_REV_WRA: ram_we = 1'b1;
      ST_REV_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hi_r);
        ram_wdata = tmp_r;
      end
      ST_READ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(tgt_r);
      end
      default: ;
    endcase
  end

  // datapath register updates
  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    ptr_nxt   = ptr_r;
    tgt_nxt   = tgt_r;
    hi_nxt    = hi_r;
    tmp_nxt   = tmp_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    full_nxt  = full_r;
    found_nxt = found_r;
    rd_nxt    = rd_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_opc;
          key_nxt   = in_key;
          ok_nxt    = 1'b0;
          full_nxt  = 1'b0;
          found_nxt = '0;
          rd_nxt    = '0;
          case (in_opc)
            OP_APPEND: begin
              full_nxt = is_full;
              ptr_nxt  = count_r;
              tgt_nxt  = count_r;
            end
            OP_INSERT: begin
              full_nxt = ins_ok && is_full;
              ptr_nxt  = count_r;
              tgt_nxt  = pos_m1;
            end
            OP_DELETE: ptr_nxt = pos_m1;
            OP_SEARCH: begin
              ok_nxt  = 1'b1;
              ptr_nxt = '0;
            end
            OP_ORDERED: begin
              full_nxt = is_full;
              ptr_nxt  = '0;
            end
            OP_REVERSE: begin
              ok_nxt  = 1'b1;
              ptr_nxt = '0;
              hi_nxt  = count_r - 1'b1;
            end
            OP_READ: tgt_nxt = pos_m1;
            default: ;
          endcase
        end
      end
      ST_SHIFT_RD: begin
        if (at_tgt) begin
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      ST_SHIFT_WR: ptr_nxt = ptr_m1;
      ST_DEL_RD: begin
        if (del_end) begin
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      ST_DEL_WR: ptr_nxt = ptr_p1;
      ST_SRCH_RD: begin
        // no element at or above the key: ordered insert lands at the tail
        if (srch_end) begin
          tgt_nxt = count_r;
        end
      end
      ST_SRCH_CMP: begin
        if (hit) begin
          if (op_r == OP_ORDERED) begin
            tgt_nxt = ptr_r;
            ptr_nxt = count_r;
          end else begin
            found_nxt = ptr_p1;
          end
        end else begin
          ptr_nxt = ptr_p1;
        end
      end
      ST_REV_RDB: tmp_nxt = ram_rdata;
      ST_REV_WRB: begin
        ptr_nxt = ptr_p1;
        hi_nxt  = hi_r - 1'b1;
      end
      ST_READ_WAIT: begin
        rd_nxt = ram_rdata;
        ok_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    ptr_r   <= ptr_nxt;
    tgt_r   <= tgt_nxt;
    hi_r    <= hi_nxt;
    tmp_r   <= tmp_nxt;
    ok_r    <= ok_nxt;
    full_r  <= full_nxt;
    found_r <= found_nxt;
    rd_r    <= rd_nxt;
  end

  // result word
  assign rd_ext = 64'($signed(rd_r));
  always_comb begin
    res.ok             = ok_r;
    res.full_flag      = full_r;
    res.found_position = CNT_O_W'(found_r);
    res.read_value     = rd_ext[VALUE_W-1:0];
    res.element_count  = CNT_O_W'(count_r);
  end

  // a taken item leaves the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("engine ready right after taking a word");

  // a finished result holds until the output stage takes it
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while waiting");

  // the compare step only looks at stored entries
  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH_CMP) |-> (ptr_r < count_r))
    else $error("search compared past the stored elements");

  // a delete move stays inside the stored elements
  a_delete_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL_WR) |-> (ptr_p1 < count_r))
    else $error("delete moved past the stored elements");

endmodule

`default_nettype wire

@@ rtl/core/indexed_sequence_store.sv @@
// indexed_sequence_store: bounded ordered list of signed values with 1-based positions.
// Input channel (in_valid/in_ready) takes one word: op, value, position. Ops are append,
// insert at position, delete at position, search, reverse, ordered insert and read.
// Result channel (out_valid/out_ready) returns one word per input word: ok, full flag,
// found position, read value and element count after the operation.
// One word is worked on at a time through a single-port-read, single-port-write RAM;
// every element move or compare is one RAM read followed by a write or a compare.
// in_ready is high only while the sequencer is idle; results land in an output
// register, so the sequencer can start the next word while a result waits there.
// If the receiver stalls with the output register full, the next finished result
// waits inside the sequencer and no new word is taken.
// Reset (rst_n low, synchronous) empties the list and clears the output valid flag;
// the RAM contents are not cleared, only entries below the count are ever read.
`default_nettype none

module indexed_sequence_store import isq_pkg::*; #(
  parameter int DEPTH      = ISQ_DEPTH,
  parameter int DATA_WIDTH = ISQ_DATA_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [OP_W-1:0]           in_op,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic [POS_W-1:0]          in_position,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_ok,
  output logic                           out_full_flag,
  output logic [CNT_O_W-1:0]             out_found_position,
  output logic signed [VALUE_W-1:0]      out_read_value,
  output logic [CNT_O_W-1:0]             out_element_count
);

  localparam int AW = $clog2(DEPTH);

  logic                  res_valid, res_ready;
  res_t                  res;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  // sequencer and datapath
  isq_engine #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_value    (in_value),
    .in_position (in_position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // element storage
  isq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register, loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_res_r.ok;
  assign out_full_flag      = out_res_r.full_flag;
  assign out_found_position = out_res_r.found_position;
  assign out_read_value     = out_res_r.read_value;
  assign out_element_count  = out_res_r.element_count;

endmodule

`default_nettype wire

@@ bench/indexed_sequence_store_test.sv @@
`timescale 1ns / 1ps

module indexed_sequence_store_test;
  import isq_pkg::*;

  // opcode seven has no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_WORDS  = 800;
  localparam int QUIET_WORDS   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * ISQ_DEPTH + 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    bit                        typed;
    res_t                      want;
  } stim_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic [OP_W-1:0]           in_op = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic                      out_ready = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      out_ok;
  logic                      out_full_flag;
  logic [CNT_O_W-1:0]        out_found_position;
  logic signed [VALUE_W-1:0] out_read_value;
  logic [CNT_O_W-1:0]        out_element_count;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] list_model [ISQ_DEPTH];
  int                        list_len = 0;

  res_t      expected_results [$];
  stim_row_t directed_rows [$];
  int        error_count = 0;
  bit        quiet = 1'b0;
  bit        hold_request = 1'b0;
  bit        hold_done = 1'b0;

  indexed_sequence_store u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_full_flag      (out_full_flag),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_element_count  (out_element_count)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // open a slot and drop a value into it
  function automatic void place_value(input int slot, input logic signed [VALUE_W-1:0] value);
    int i;
    for (i = list_len; i > slot; i--) list_model[i] = list_model[i - 1];
    list_model[slot] = value;
    list_len++;
  endfunction

  // apply one word to the shadow list and return the result it should give
  function automatic res_t predict_word(input logic [OP_W-1:0] op,
                                        input logic signed [VALUE_W-1:0] value,
                                        input logic [POS_W-1:0] position);
    res_t r;
    int   i;
    int   p;
    logic signed [VALUE_W-1:0] t;
    r = '0;
    p = int'(position);
    case (op)
      OP_APPEND: begin
        if (list_len >= ISQ_DEPTH) begin
          r.full_flag = 1'b1;
        end else begin
          place_value(list_len, value);
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1) begin
          if (list_len >= ISQ_DEPTH) begin
            r.full_flag = 1'b1;
          end else begin
            place_value(p - 1, value);
            r.ok = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          for (i = p - 1; i + 1 < list_len; i++) list_model[i] = list_model[i + 1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        r.ok = 1'b1;
        // walk down so the lowest match wins
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_model[i] == value) r.found_position = CNT_O_W'(i + 1);
        end
      end
      OP_REVERSE: begin
        r.ok = 1'b1;
        for (i = 0; i < list_len / 2; i++) begin
          t = list_model[i];
          list_model[i] = list_model[list_len - 1 - i];
          list_model[list_len - 1 - i] = t;
        end
      end
      OP_ORDERED: begin
        if (list_len >= ISQ_DEPTH) begin
          r.full_flag = 1'b1;
        end else begin
          i = 0;
          while (i < list_len && value > list_model[i]) i++;
          place_value(i, value);
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (p >= 1 && p <= list_len) begin
          r.read_value = list_model[p - 1];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.element_count = CNT_O_W'(list_len);
    return r;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op,
                                  input logic signed [VALUE_W-1:0] value,
                                  input logic [POS_W-1:0] position, input bit typed,
                                  input logic ok, input int found,
                                  input logic signed [VALUE_W-1:0] read_value,
                                  input int count);
    stim_row_t row;
    row.op = op;
    row.value = value;
    row.position = position;
    row.typed = typed;
    row.want = '0;
    row.want.ok = ok;
    row.want.found_position = CNT_O_W'(found);
    row.want.read_value = read_value;
    row.want.element_count = CNT_O_W'(count);
    directed_rows.push_back(row);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // value pool: stored values, extremes, a small cluster, then anything
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25 && list_len > 0) return list_model[$urandom_range(0, list_len - 1)];
    if (roll < 40) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    if (roll < 55) return $urandom_range(0, 15) - 8;
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input traffic_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 25) return OP_APPEND;
        if (roll < 50) return OP_INSERT;
        if (roll < 70) return OP_ORDERED;
      end
      MODE_DRAIN: begin
        if (roll < 55) return OP_DELETE;
      end
      default: begin
      end
    endcase
    return OP_W'($urandom_range(0, 7));
  endfunction

  // mostly in-range positions, with some noise over the whole field
  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 255));
    if (op == OP_INSERT) return POS_W'($urandom_range(1, list_len + 1));
    if (list_len > 0) return POS_W'($urandom_range(1, list_len));
    return POS_W'($urandom_range(0, 2));
  endfunction

  // hold one word on the input until it is taken
  task automatic offer_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] position, input res_t want);
    expected_results.push_back(want);
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= value;
    in_position <= position;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random sender gap
  task automatic rest_sender();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // stimulus: directed table, then random episodes
  initial begin : stimulus
    stim_row_t            row;
    res_t                 want;
    traffic_mode_t        mode;
    int                   episode_left;
    int                   sent;
    logic [OP_W-1:0]      op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]     position;

    // empty store: failed reads, deletes and inserts, search and reverse on nothing, an unused opcode
    add_row(OP_READ,    0,       8'd1,   1, 0, 0, 0,       0);
    add_row(OP_DELETE,  0,       8'd1,   1, 0, 0, 0,       0);
    add_row(OP_SEARCH,  0,       8'd0,   1, 1, 0, 0,       0);
    add_row(OP_REVERSE, 0,       8'd0,   1, 1, 0, 0,       0);
    add_row(OP_UNUSED,  -1,      8'd255, 1, 0, 0, 0,       0);
    add_row(OP_INSERT,  5,       8'd0,   1, 0, 0, 0,       0);
    add_row(OP_INSERT,  5,       8'd2,   1, 0, 0, 0,       0);
    add_row(OP_ORDERED, 5,       8'd0,   1, 1, 0, 0,       1);
    // ordered insert with nothing larger lands at the end
    add_row(OP_ORDERED, 9,       8'd0,   1, 1, 0, 0,       2);
    add_row(OP_APPEND,  VAL_MIN, 8'd0,   1, 1, 0, 0,       3);
    add_row(OP_APPEND,  VAL_MAX, 8'd0,   1, 1, 0, 0,       4);
    add_row(OP_READ,    0,       8'd3,   1, 1, 0, VAL_MIN, 4);
    add_row(OP_READ,    0,       8'd4,   1, 1, 0, VAL_MAX, 4);
    add_row(OP_READ,    0,       8'd0,   1, 0, 0, 0,       4);
    add_row(OP_READ,    0,       8'd255, 1, 0, 0, 0,       4);
    // rows below, but for the typed one, are checked against the shadow list
    add_row(OP_INSERT,  0,       8'd5,   0, 0, 0, 0,       0);
    add_row(OP_INSERT,  -1,      8'd1,   0, 0, 0, 0,       0);
    add_row(OP_ORDERED, VAL_MAX, 8'd0,   0, 0, 0, 0,       0);
    add_row(OP_ORDERED, 6,       8'd0,   0, 0, 0, 0,       0);
    add_row(OP_SEARCH,  VAL_MAX, 8'd0,   0, 0, 0, 0,       0);
    add_row(OP_SEARCH,  12345,   8'd0,   0, 0, 0, 0,       0);
    add_row(OP_REVERSE, 0,       8'd0,   0, 0, 0, 0,       0);
    // tail delete, then head delete
    add_row(OP_DELETE,  0,       8'd8,   0, 0, 0, 0,       0);
    add_row(OP_READ,    0,       8'd7,   0, 0, 0, 0,       0);
    add_row(OP_DELETE,  0,       8'd1,   0, 0, 0, 0,       0);
    add_row(OP_DELETE,  0,       8'd255, 1, 0, 0, 0,       6);
    add_row(OP_DELETE,  0,       8'd7,   0, 0, 0, 0,       0);

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      want = predict_word(row.op, row.value, row.position);
      if (row.typed) want = row.want;
      offer_word(row.op, row.value, row.position, want);
      rest_sender();
    end

    // first episode fills the store while the receiver is held off once
    mode = MODE_FILL;
    episode_left = 120;
    hold_request = 1'b1;
    for (sent = 0; sent < RANDOM_WORDS; sent++) begin
      if (episode_left == 0) begin
        mode = traffic_mode_t'($urandom_range(0, 2));
        episode_left = $urandom_range(20, 80);
      end
      episode_left--;
      if (RANDOM_WORDS - sent == QUIET_WORDS) quiet = 1'b1;
      op = pick_op(mode);
      value = pick_value();
      position = pick_position(op);
      offer_word(op, value, position, predict_word(op, value, position));
      rest_sender();
    end
    in_valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("indexed_sequence_store_test: clean");
    end else begin
      $display("indexed_sequence_store_test: errors");
    end
    $finish;
  end

  // receiver: random ready bursts, one long hold, always ready at the end
  initial begin : ready_driver
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.ok = out_ok;
      got.full_flag = out_full_flag;
      got.found_position = out_found_position;
      got.read_value = out_read_value;
      got.element_count = out_element_count;
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result word, count %0d", out_element_count));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          note_error($sformatf(
            "result mismatch (exp/got): ok %0b/%0b full %0b/%0b found %0d/%0d",
            want.ok, got.ok, want.full_flag, got.full_flag,
            want.found_position, got.found_position));
          if (error_count <= REPORT_LIMIT) begin
            $display("  read %h/%h count %0d/%0d", want.read_value, got.read_value,
                     want.element_count, got.element_count);
          end
        end
      end
    end
  end

  // timeout
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("indexed_sequence_store_test: errors");
    $finish;
  end

endmodule
